[sv/polyline_offset_edges_macros.svh]
// assertion macros for the polyline offset edge block
`ifndef POLYLINE_OFFSET_EDGES_MACROS_SVH
`define POLYLINE_OFFSET_EDGES_MACROS_SVH
// property that must hold at every clock edge outside reset
`define POE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// implication form
`define POE_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`endif

[sv/poe_pkg.sv]
// shared types and constants of the polyline offset edge block
`timescale 1ns / 1ps
package poe_pkg;
    localparam int OUT_BITS = 21;
    localparam int HW_BITS = 8;
    localparam int ISO_BITS = 12;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ISO_DIVISOR = 1'd1;
    localparam logic [HW_BITS-1:0] HW_RESET = 8'd25;
    localparam logic [ISO_BITS-1:0] ISO_RESET = 12'd512;
    localparam logic [ISO_BITS-1:0] ISO_MIN = 12'd256;
    // operation codes of the shared unit
    typedef enum logic [1:0] {
        OP_SQRT,
        OP_DIV
    } op_t;
    typedef struct packed {
        logic  start;
        op_t   op;
    } unit_ctl_t;
endpackage

[sv/poe_if.sv]
// valid/ready channel interfaces of the polyline offset edge block
`timescale 1ns / 1ps
interface poe_in_if #(parameter int COORD_BITS = 16);
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic end_of_route;
    modport source (output valid, point_x, point_y, end_of_route, input ready);
    modport sink (input valid, point_x, point_y, end_of_route, output ready);
endinterface

interface poe_out_if;
    logic valid;
    logic ready;
    logic signed [20:0] left_x;
    logic signed [20:0] left_y;
    logic signed [20:0] right_x;
    logic signed [20:0] right_y;
    logic final_edge_point;
    modport source (output valid, left_x, left_y, right_x, right_y, final_edge_point,
                    input ready);
    modport sink (input valid, left_x, left_y, right_x, right_y, final_edge_point,
                  output ready);
endinterface

[sv/poe_unit.sv]
// shared bit-serial unit: square root and unsigned division, one bit per cycle
`timescale 1ns / 1ps
module poe_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  poe_pkg::unit_ctl_t    ctl,
    input  logic [63:0]           opa,
    input  logic [63:0]           opb,
    output logic                  busy,
    output logic [63:0]           result
);
    logic [6:0]   cnt_reg, cnt_next;
    poe_pkg::op_t op_reg, op_next;
    logic [63:0]  num_reg, num_next;
    logic [63:0]  den_reg, den_next;
    logic [64:0]  rem_reg, rem_next;
    logic [63:0]  q_reg, q_next;
    logic [64:0]  trial;
    logic [64:0]  rem_sh;

    assign busy = (cnt_reg != 7'd0);
    assign result = q_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        op_next = op_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        rem_sh = '0;
        trial = '0;
        if (ctl.start)
        begin
            op_next = ctl.op;
            num_next = opa;
            den_next = opb;
            rem_next = '0;
            q_next = '0;
            cnt_next = (ctl.op == poe_pkg::OP_SQRT) ? 7'd32 : 7'd64;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 7'd1;
            unique case (op_reg)
                poe_pkg::OP_SQRT:
                begin
                    // two radicand bits per step, trial 4q+1
                    rem_sh = {rem_reg[62:0], num_reg[63:62]};
                    trial = {q_reg[62:0], 2'b01};
                    num_next = {num_reg[61:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_next = rem_sh - trial;
                        q_next = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next = {q_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    rem_sh = {rem_reg[63:0], num_reg[63]};
                    trial = {1'b0, den_reg};
                    num_next = {num_reg[62:0], 1'b0};
                    if (rem_sh >= trial)
                    begin
                        rem_next = rem_sh - trial;
                        q_next = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        q_next = {q_reg[62:0], 1'b0};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
    end
endmodule

[sv/poe_seq.sv]
// sequencer: vertex history, vector arithmetic and result registers
`timescale 1ns / 1ps
module poe_seq #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_BITS-1:0]         in_x,
    input  logic signed [COORD_BITS-1:0]         in_y,
    input  logic                                 in_last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [poe_pkg::OUT_BITS-1:0]  lx,
    output logic signed [poe_pkg::OUT_BITS-1:0]  ly,
    output logic signed [poe_pkg::OUT_BITS-1:0]  rx,
    output logic signed [poe_pkg::OUT_BITS-1:0]  ry,
    output logic                                 fin,
    input  logic [poe_pkg::HW_BITS-1:0]          hw,
    input  logic [poe_pkg::ISO_BITS-1:0]         iso,
    output poe_pkg::unit_ctl_t                   uctl,
    output logic [63:0]                          opa,
    output logic [63:0]                          opb,
    input  logic                                 ubusy,
    input  logic [63:0]                          ures
);
    localparam int DB = COORD_BITS + 1;
    // magnitude width: holds any difference before halving
    localparam int MB = (DB > 18) ? DB : 18;

    typedef enum logic [4:0] {
        S_IDLE, S_SEG, S_SHRINK, S_L2, S_LEN, S_LENW, S_UX, S_UXW, S_UY, S_UYW,
        S_SUM, S_M, S_MW, S_OX, S_OXW, S_DEN, S_OY, S_OYW, S_OUT, S_WAIT
    } state_t;

    state_t state_reg;
    logic [1:0] seen_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg, nx_reg, ny_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic last_reg;
    logic [1:0] emit_reg;     // which emission is in progress
    logic seg_reg;            // which segment of the pair
    logic signed [DB-1:0] dx_reg, dy_reg;
    logic [MB-1:0] mx_reg, my_reg;
    logic nxs_reg, nys_reg;
    logic [63:0] len_reg;
    logic signed [19:0] u0x_reg, u0y_reg, ux_reg;
    logic signed [20:0] sx_reg, sy_reg;
    logic [63:0] m_reg;
    logic signed [47:0] ofx_reg, ofy_reg;
    logic [63:0] den_reg;
    logic valid_reg;
    logic signed [poe_pkg::OUT_BITS-1:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic fin_reg;
    logic zero_reg;
    logic [poe_pkg::ISO_BITS-1:0] isoc;
    logic signed [COORD_BITS-1:0] cpx, cpy;
    logic [20:0] sxm, sym;
    logic [63:0] mag_num;

    assign in_ready = (state_reg == S_IDLE) && !valid_reg;
    assign out_valid = valid_reg;
    assign lx = lx_reg;
    assign ly = ly_reg;
    assign rx = rx_reg;
    assign ry = ry_reg;
    assign fin = fin_reg;
    assign isoc = (iso < poe_pkg::ISO_MIN) ? poe_pkg::ISO_MIN : iso;
    assign sxm = sx_reg[20] ? 21'(-sx_reg) : 21'(sx_reg);
    assign sym = sy_reg[20] ? 21'(-sy_reg) : 21'(sy_reg);
    // center point of the emission in progress
    assign cpx = (emit_reg == 2'd1) ? px_reg : nx_reg;
    assign cpy = (emit_reg == 2'd1) ? py_reg : ny_reg;

    // unit operands; for divisions the dividend magnitude plus half divisor for round-half-away
    always_comb
    begin
        mag_num = '0;
        opa = '0;
        opb = '0;
        uctl = '{start: 1'b0, op: poe_pkg::OP_SQRT};
        unique case (state_reg)
            S_LEN:
            begin
                opa = 64'(({46'd0, mx_reg[17:0]} * {46'd0, mx_reg[17:0]}
                          + {46'd0, my_reg[17:0]} * {46'd0, my_reg[17:0]}) << 16);
                uctl = '{start: 1'b1, op: poe_pkg::OP_SQRT};
            end
            S_UX:
            begin
                mag_num = {22'd0, my_reg[17:0], 24'd0};
                opa = mag_num + (len_reg >> 1);
                opb = len_reg;
                uctl = '{start: 1'b1, op: poe_pkg::OP_DIV};
            end
            S_UY:
            begin
                mag_num = {22'd0, mx_reg[17:0], 24'd0};
                opa = mag_num + (len_reg >> 1);
                opb = len_reg;
                uctl = '{start: 1'b1, op: poe_pkg::OP_DIV};
            end
            S_M:
            begin
                opa = 64'(({43'd0, sxm} * {43'd0, sxm} + {43'd0, sym} * {43'd0, sym}) << 16);
                uctl = '{start: 1'b1, op: poe_pkg::OP_SQRT};
            end
            S_OX:
            begin
                mag_num = 64'({43'd0, sxm} * {56'd0, hw}) << (FRAC_BITS + 8);
                opa = mag_num + (m_reg >> 1);
                opb = m_reg;
                uctl = '{start: 1'b1, op: poe_pkg::OP_DIV};
            end
            S_OY:
            begin
                mag_num = 64'({43'd0, sym} * {56'd0, hw}) << (FRAC_BITS + 16);
                opa = mag_num + (den_reg >> 1);
                opb = den_reg;
                uctl = '{start: 1'b1, op: poe_pkg::OP_DIV};
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg <= '0;
            valid_reg <= 1'b0;
            ox_reg <= '0;
            oy_reg <= '0;
            nx_reg <= '0;
            ny_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            emit_reg <= '0;
            seg_reg <= 1'b0;
            last_reg <= 1'b0;
            dx_reg <= '0;
            dy_reg <= '0;
            mx_reg <= '0;
            my_reg <= '0;
            nxs_reg <= 1'b0;
            nys_reg <= 1'b0;
            len_reg <= '0;
            u0x_reg <= '0;
            u0y_reg <= '0;
            ux_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            m_reg <= '0;
            ofx_reg <= '0;
            ofy_reg <= '0;
            den_reg <= '0;
            lx_reg <= '0;
            ly_reg <= '0;
            rx_reg <= '0;
            ry_reg <= '0;
            fin_reg <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            if (valid_reg && out_ready)
                valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        px_reg <= in_x;
                        py_reg <= in_y;
                        last_reg <= in_last;
                        emit_reg <= 2'd0;
                        seg_reg <= 1'b0;
                        if (seen_reg == 2'd0 && !in_last)
                        begin
                            nx_reg <= in_x;
                            ny_reg <= in_y;
                            seen_reg <= 2'd1;
                        end
                        else if (seen_reg == 2'd0)
                        begin
                            // single point route
                            emit_reg <= 2'd1;
                            sx_reg <= '0;
                            sy_reg <= '0;
                            state_reg <= S_SUM;
                        end
                        else
                            state_reg <= S_SEG;
                    end
                end
                S_SEG:
                begin
                    // first segment is older->newer unless at route start or in the end emission
                    if (!seg_reg && emit_reg == 2'd0 && seen_reg == 2'd2)
                    begin
                        dx_reg <= DB'(nx_reg) - DB'(ox_reg);
                        dy_reg <= DB'(ny_reg) - DB'(oy_reg);
                    end
                    else
                    begin
                        dx_reg <= DB'(px_reg) - DB'(nx_reg);
                        dy_reg <= DB'(py_reg) - DB'(ny_reg);
                    end
                    state_reg <= S_SHRINK;
                end
                S_SHRINK:
                begin
                    nxs_reg <= dx_reg[DB-1];
                    nys_reg <= dy_reg[DB-1];
                    mx_reg <= MB'(dx_reg[DB-1] ? -dx_reg : dx_reg);
                    my_reg <= MB'(dy_reg[DB-1] ? -dy_reg : dy_reg);
                    state_reg <= S_L2;
                end
                S_L2:
                begin
                    if ((mx_reg >> 17) != '0 || (my_reg >> 17) != '0)
                    begin
                        mx_reg <= mx_reg >> 1;
                        my_reg <= my_reg >> 1;
                    end
                    else if (mx_reg == '0 && my_reg == '0)
                    begin
                        ux_reg <= '0;
                        state_reg <= S_UYW;
                        zero_reg <= 1'b1;
                    end
                    else
                    begin
                        zero_reg <= 1'b0;
                        state_reg <= S_LEN;
                    end
                end
                S_LEN: state_reg <= S_LENW;
                S_LENW:
                    if (!ubusy)
                    begin
                        len_reg <= ures;
                        state_reg <= S_UX;
                    end
                S_UX: state_reg <= S_UXW;
                S_UXW:
                    if (!ubusy)
                    begin
                        ux_reg <= (!nys_reg && my_reg != '0) ? -20'(ures) : 20'(ures);
                        state_reg <= S_UY;
                    end
                S_UY: state_reg <= S_UYW;
                S_UYW:
                    if (!ubusy)
                    begin
                        if (!seg_reg)
                        begin
                            u0x_reg <= ux_reg;
                            u0y_reg <= zero_reg ? 20'sd0 :
                                       (nxs_reg ? -20'(ures) : 20'(ures));
                            // end segments count twice
                            if (emit_reg == 2'd1 || seen_reg == 2'd1)
                            begin
                                sx_reg <= 21'(ux_reg) + 21'(ux_reg);
                                sy_reg <= zero_reg ? 21'sd0 :
                                          (nxs_reg ? -21'(ures) - 21'(ures)
                                                   : 21'(ures) + 21'(ures));
                                state_reg <= S_SUM;
                            end
                            else
                            begin
                                seg_reg <= 1'b1;
                                state_reg <= S_SEG;
                            end
                        end
                        else
                        begin
                            sx_reg <= 21'(u0x_reg) + 21'(ux_reg);
                            sy_reg <= 21'(u0y_reg) + (zero_reg ? 21'sd0 :
                                      (nxs_reg ? -21'(ures) : 21'(ures)));
                            state_reg <= S_SUM;
                        end
                    end
                S_SUM:
                begin
                    if (sx_reg == '0 && sy_reg == '0)
                    begin
                        ofx_reg <= '0;
                        ofy_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_M;
                end
                S_M: state_reg <= S_MW;
                S_MW:
                    if (!ubusy)
                    begin
                        m_reg <= ures;
                        state_reg <= S_OX;
                    end
                S_OX: state_reg <= S_OXW;
                S_OXW:
                    if (!ubusy)
                    begin
                        ofx_reg <= sx_reg[20] ? -48'(ures) : 48'(ures);
                        state_reg <= S_DEN;
                    end
                S_DEN:
                begin
                    den_reg <= 64'(m_reg[31:0] * {20'd0, isoc});
                    state_reg <= S_OY;
                end
                S_OY: state_reg <= S_OYW;
                S_OYW:
                    if (!ubusy)
                    begin
                        ofy_reg <= sy_reg[20] ? -48'(ures) : 48'(ures);
                        state_reg <= S_OUT;
                    end
                S_OUT:
                begin
                    if (!valid_reg)
                    begin
                        lx_reg <= poe_pkg::OUT_BITS'((48'(cpx) <<< FRAC_BITS) + ofx_reg);
                        ly_reg <= poe_pkg::OUT_BITS'((48'(cpy) <<< FRAC_BITS) + ofy_reg);
                        rx_reg <= poe_pkg::OUT_BITS'((48'(cpx) <<< FRAC_BITS) - ofx_reg);
                        ry_reg <= poe_pkg::OUT_BITS'((48'(cpy) <<< FRAC_BITS) - ofy_reg);
                        fin_reg <= (emit_reg == 2'd1);
                        valid_reg <= 1'b1;
                        state_reg <= S_WAIT;
                    end
                end
                default:
                begin
                    // S_WAIT: wait for result taken, then end emission, next vertex or route done
                    if (!valid_reg)
                    begin
                        if (emit_reg == 2'd0 && last_reg)
                        begin
                            emit_reg <= 2'd1;
                            seg_reg <= 1'b0;
                            state_reg <= S_SEG;
                        end
                        else if (last_reg)
                        begin
                            seen_reg <= '0;
                            ox_reg <= '0;
                            oy_reg <= '0;
                            nx_reg <= '0;
                            ny_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ox_reg <= nx_reg;
                            oy_reg <= ny_reg;
                            nx_reg <= px_reg;
                            ny_reg <= py_reg;
                            seen_reg <= 2'd2;
                            state_reg <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end
endmodule

[sv/polyline_offset_edges.sv]
// top level of the polyline offset edge block
//
//  channel  dir  payload
//  vin      in   point_x, point_y, end_of_route
//  vout     out  left_x, left_y, right_x, right_y, final_edge_point
//  cfg      in   cfg_we, cfg_index, cfg_data
//
// each segment takes one 32-step root and two 64-step divisions,
// each result one more root and two divisions; a zero segment skips the unit
// the first vertex of a route gives no result unless it also ends the route
// not ready while a vertex is in work; a stalled result holds the sequencer
// rst_n clears history and restores half_width 25 and iso_divisor 512
`timescale 1ns / 1ps
module polyline_offset_edges #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS = 4
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    poe_in_if.sink                                 vin,
    poe_out_if.source                              vout,
    input  logic                                   cfg_we,
    input  logic [poe_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [poe_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    logic [poe_pkg::HW_BITS-1:0]  hw_reg;
    logic [poe_pkg::ISO_BITS-1:0] iso_reg;
    poe_pkg::unit_ctl_t uctl;
    logic [63:0] opa, opb, ures;
    logic ubusy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= poe_pkg::HW_RESET;
            iso_reg <= poe_pkg::ISO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                poe_pkg::REG_HALF_WIDTH: hw_reg <= cfg_data[poe_pkg::HW_BITS-1:0];
                default: iso_reg <= cfg_data;
            endcase
        end
    end

    poe_unit u_unit (
        .clk(clk), .rst_n(rst_n), .ctl(uctl), .opa(opa), .opb(opb),
        .busy(ubusy), .result(ures)
    );

    poe_seq #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(vin.valid), .in_ready(vin.ready),
        .in_x(vin.point_x), .in_y(vin.point_y), .in_last(vin.end_of_route),
        .out_valid(vout.valid), .out_ready(vout.ready),
        .lx(vout.left_x), .ly(vout.left_y), .rx(vout.right_x), .ry(vout.right_y),
        .fin(vout.final_edge_point),
        .hw(hw_reg), .iso(iso_reg),
        .uctl(uctl), .opa(opa), .opb(opb), .ubusy(ubusy), .ures(ures)
    );
endmodule

[sv/poe_checker.sv]
// port-level assertions of the polyline offset edge block and their binding
`timescale 1ns / 1ps
`include "polyline_offset_edges_macros.svh"
module poe_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_final
);
    // a waiting result stays until taken
    `POE_ASSERT_IMP(out_hold, out_valid && !out_ready, ##1 out_valid)
    // no new request is taken while a result waits
    `POE_ASSERT_IMP(no_in_while_out, out_valid, !in_ready)
    // a shown result carries a known final flag
    `POE_ASSERT(fin_known, !out_valid || !$isunknown(out_final))
    // final flag holds while the result waits
    `POE_ASSERT_IMP(fin_hold, out_valid && !out_ready, ##1 $stable(out_final))
endmodule

bind polyline_offset_edges poe_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(vin.valid), .in_ready(vin.ready),
    .out_valid(vout.valid), .out_ready(vout.ready), .out_final(vout.final_edge_point)
);
